>>> design/chained_hash_map_assert.svh
// Assertion macros for the hash map RTL.
`ifndef CHAINED_HASH_MAP_ASSERT_SVH
`define CHAINED_HASH_MAP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CHM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cmap_pkg.sv
// Shared constants, codes and control structs of the hash map.
`timescale 1ns / 1ps
package cmap_pkg;
	localparam int NUM_BUCKETS_DEF  = 255;
	localparam int POOL_ENTRIES_DEF = 256;
	localparam int KEY_BITS_DEF     = 32;
	localparam int VALUE_BITS_DEF   = 32;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_BADKEY  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic       load;      // capture input item
		logic       clr_wr;    // clear one bucket head
		logic       mod_step;  // one byte of key mod buckets
		logic       head_rd;   // read bucket head
		logic       head_cap;  // start walk at head
		logic       free_rd;   // read link of free list head
		logic       ins_free;  // insert into recycled slot
		logic       ins_new;   // insert into never-used slot
		logic       node_rd;   // read entry at cur
		logic       advance;   // step to next link
		logic       unlink;    // bypass matched entry
		logic       rel_slot;  // push matched entry on free list
		logic       res_load;  // load output register
		logic [1:0] res_status;
		logic       res_found;
	} cmap_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       mod_last;
		logic [1:0] cmd;
		logic       key_zero;
		logic       free_nil;
		logic       nu_full;
		logic       cur_nil;
		logic       steps_max;
		logic       key_match;
		logic       out_free;
	} cmap_sts_t;
endpackage

>>> design/cmap_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cmap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> design/cmap_ctrl.sv
// Sequencer of the hash map: clear pass, hashing, insert and chain walk.
`timescale 1ns / 1ps
module cmap_ctrl import cmap_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  cmap_sts_t  sts,
	output cmap_cmd_t  cmd
);
	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CHK    = 4'd2;
	localparam logic [3:0] S_MOD    = 4'd3;
	localparam logic [3:0] S_HEAD   = 4'd4;
	localparam logic [3:0] S_HEADW  = 4'd5;
	localparam logic [3:0] S_INS    = 4'd6;
	localparam logic [3:0] S_WALK   = 4'd7;
	localparam logic [3:0] S_CMP    = 4'd8;
	localparam logic [3:0] S_UNLINK = 4'd9;
	localparam logic [3:0] S_REL    = 4'd10;
	localparam logic [3:0] S_RES    = 4'd11;

	logic [3:0] state_q, state_d;
	logic [1:0] res_st_q, res_st_d;
	logic       found_q, found_d;
	logic       use_free_q, use_free_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		res_st_d   = res_st_q;
		found_d    = found_q;
		use_free_d = use_free_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				found_d = 1'b0;
				if (sts.cmd == CMD_NOP) begin
					res_st_d = ST_OK;
					state_d  = S_RES;
				end else if (sts.key_zero) begin
					res_st_d = ST_BADKEY;
					state_d  = S_RES;
				end else begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d     = S_HEADW;
			end
			S_HEADW: begin
				cmd.head_cap = 1'b1;
				if (sts.cmd == CMD_INSERT) begin
					if (!sts.free_nil) begin
						cmd.free_rd = 1'b1;
						use_free_d  = 1'b1;
						state_d     = S_INS;
					end else if (!sts.nu_full) begin
						use_free_d = 1'b0;
						state_d    = S_INS;
					end else begin
						res_st_d = ST_FULL;
						state_d  = S_RES;
					end
				end else begin
					state_d = S_WALK;
				end
			end
			S_INS: begin
				cmd.ins_free = use_free_q;
				cmd.ins_new  = !use_free_q;
				res_st_d     = ST_OK;
				state_d      = S_RES;
			end
			S_WALK: begin
				if (sts.cur_nil || sts.steps_max) begin
					res_st_d = ST_MISSING;
					state_d  = S_RES;
				end else begin
					cmd.node_rd = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.key_match) begin
					if (sts.cmd == CMD_LOOKUP) begin
						found_d  = 1'b1;
						res_st_d = ST_OK;
						state_d  = S_RES;
					end else begin
						state_d = S_UNLINK;
					end
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_WALK;
				end
			end
			S_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d    = S_REL;
			end
			S_REL: begin
				cmd.rel_slot = 1'b1;
				res_st_d     = ST_OK;
				state_d      = S_RES;
			end
			S_RES: begin
				if (sts.out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = res_st_q;
					cmd.res_found  = found_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			res_st_q   <= ST_OK;
			found_q    <= 1'b0;
			use_free_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			res_st_q   <= res_st_d;
			found_q    <= found_d;
			use_free_q <= use_free_d;
		end
	end
endmodule

>>> design/cmap_dp.sv
// Datapath of the hash map: item registers, key hashing, memories, output register.
`timescale 1ns / 1ps
`include "chained_hash_map_assert.svh"
module cmap_dp import cmap_pkg::*; #(
	parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
	parameter int KEY_BITS     = KEY_BITS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF,
	localparam int PW = $clog2(POOL_ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            cmd_in,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value_in,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] value_out,
	output logic [PW-1:0]         entry_total,
	input  cmap_cmd_t             cmd,
	output cmap_sts_t             sts
);
	localparam int BW   = $clog2(NUM_BUCKETS);
	localparam int AW   = $clog2(POOL_ENTRIES);
	localparam int DIG  = 8;
	localparam int NDIG = (KEY_BITS + DIG - 1) / DIG;
	localparam int KPW  = NDIG * DIG;
	localparam int XW   = BW + DIG;
	localparam int MCW  = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);
	// floor(2^XW / buckets): quotient estimate is exact or one short
	localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / 64'(NUM_BUCKETS));
	localparam logic [XW-1:0] NB_X  = XW'(NUM_BUCKETS);

	logic [1:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KPW-1:0]        ksh_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [BW-1:0]         rem_q, clr_q, rem_d;
	logic [MCW-1:0]        mcnt_q;
	logic [PW-1:0]         head_q, cur_q, prev_q, steps_q, free_q, nu_q, live_q, live_d;
	logic                  out_valid_q;
	logic [XW-1:0]         mod_x, mod_est, mod_r;
	logic [2*XW-1:0]       mod_prod;

	logic [PW-1:0]         head_rd, link_rd, slot;
	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] val_rd;

	logic                  bk_we;
	logic [BW-1:0]         bk_waddr;
	logic [PW-1:0]         bk_wdata;
	logic                  ln_we;
	logic [AW-1:0]         ln_waddr, ln_raddr;
	logic [PW-1:0]         ln_wdata;
	logic                  ins;

	assign ins   = cmd.ins_free || cmd.ins_new;
	assign slot  = cmd.ins_free ? free_q : nu_q;

	// One key byte per step: rem = (rem * 256 + byte) mod buckets.
	always_comb begin
		mod_x    = {rem_q, ksh_q[KPW-1 -: DIG]};
		mod_prod = (2 * XW)'(mod_x) * (2 * XW)'(RECIP);
		mod_est  = mod_prod[2*XW-1:XW];
		mod_r    = mod_x - mod_est * NB_X;
		if (mod_r >= NB_X) begin
			rem_d = BW'(mod_r - NB_X);
		end else begin
			rem_d = mod_r[BW-1:0];
		end
	end

	always_comb begin
		bk_we    = 1'b0;
		bk_waddr = rem_q;
		bk_wdata = slot;
		if (cmd.clr_wr) begin
			bk_we    = 1'b1;
			bk_waddr = clr_q;
			bk_wdata = NIL;
		end else if (ins) begin
			bk_we = 1'b1;
		end else if (cmd.unlink && prev_q == NIL) begin
			bk_we    = 1'b1;
			bk_wdata = link_rd;
		end
	end

	always_comb begin
		ln_we    = 1'b0;
		ln_waddr = slot[AW-1:0];
		ln_wdata = head_q;
		if (ins) begin
			ln_we = 1'b1;
		end else if (cmd.unlink && prev_q != NIL) begin
			ln_we    = 1'b1;
			ln_waddr = prev_q[AW-1:0];
			ln_wdata = link_rd;
		end else if (cmd.rel_slot) begin
			ln_we    = 1'b1;
			ln_waddr = cur_q[AW-1:0];
			ln_wdata = free_q;
		end
	end

	assign ln_raddr = cmd.free_rd ? free_q[AW-1:0] : cur_q[AW-1:0];

	cmap_ram #(.WIDTH(PW), .DEPTH(NUM_BUCKETS)) u_bucket (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
		.re(cmd.head_rd), .raddr(rem_q), .rdata(head_rd)
	);
	cmap_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_links (
		.clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
		.re(cmd.free_rd || cmd.node_rd), .raddr(ln_raddr), .rdata(link_rd)
	);
	cmap_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_ENTRIES)) u_keys (
		.clk(clk), .we(ins), .waddr(slot[AW-1:0]), .wdata(key_q),
		.re(cmd.node_rd), .raddr(cur_q[AW-1:0]), .rdata(key_rd)
	);
	cmap_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_ENTRIES)) u_values (
		.clk(clk), .we(ins), .waddr(slot[AW-1:0]), .wdata(val_q),
		.re(cmd.node_rd), .raddr(cur_q[AW-1:0]), .rdata(val_rd)
	);

	always_comb begin
		live_d = live_q;
		if (ins) begin
			live_d = live_q + PW'(1);
		end else if (cmd.rel_slot && live_q != '0) begin
			live_d = live_q - PW'(1);
		end
	end

	always_comb begin
		sts.clr_last  = (clr_q == BW'(NUM_BUCKETS - 1));
		sts.mod_last  = (mcnt_q == MCW'(NDIG - 1));
		sts.cmd       = cmd_q;
		sts.key_zero  = (key_q == '0);
		sts.free_nil  = (free_q == NIL);
		sts.nu_full   = (nu_q == NIL);
		sts.cur_nil   = (cur_q == NIL);
		sts.steps_max = (steps_q == NIL);
		sts.key_match = (key_rd == key_q);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// Item registers, walk pointers and result outputs.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_in;
			key_q <= key;
			ksh_q <= KPW'(key);
			val_q <= value_in;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			ksh_q <= ksh_q << DIG;
			rem_q <= rem_d;
		end
		if (cmd.head_cap) begin
			head_q  <= head_rd;
			cur_q   <= head_rd;
			prev_q  <= NIL;
			steps_q <= '0;
		end else if (cmd.advance) begin
			prev_q  <= cur_q;
			cur_q   <= link_rd;
			steps_q <= steps_q + PW'(1);
		end
		if (cmd.res_load) begin
			status      <= cmd.res_status;
			value_out   <= cmd.res_found ? val_rd : '0;
			entry_total <= live_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			mcnt_q      <= '0;
			free_q      <= NIL;
			nu_q        <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + BW'(1);
			end
			if (cmd.load) begin
				mcnt_q <= '0;
			end else if (cmd.mod_step) begin
				mcnt_q <= mcnt_q + MCW'(1);
			end
			if (cmd.ins_free) begin
				free_q <= link_rd;
			end else if (cmd.rel_slot) begin
				free_q <= cur_q;
			end
			if (cmd.ins_new) begin
				nu_q <= nu_q + PW'(1);
			end
			live_q <= live_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`CHM_ASSERT_IMPL(a_live_bound, 1'b1, live_q <= NIL, "live count above pool size")
	`CHM_ASSERT_NEXT(a_ins_count, ins, live_q == $past(live_q) + PW'(1), "insert missed count")
	`CHM_ASSERT_IMPL(a_ins_room, cmd.ins_new, nu_q != NIL, "insert from exhausted pool")
	`CHM_ASSERT_IMPL(a_res_room, cmd.res_load, !out_valid_q || !out_stall,
		"result overwrote pending item")
endmodule

>>> design/chained_hash_map.sv
// Top level of the chained hash map: sequencer plus datapath.
`timescale 1ns / 1ps
// Integer-keyed hash map with separate chaining over a fixed entry pool.
// Input channel (in_valid/in_stall): cmd (insert, delete, lookup), key, value_in.
// Output channel (out_valid/out_stall): status, value_out, entry_total; one
// result item per input item, in order.
// Bucket = key mod NUM_BUCKETS, reduced one key byte per cycle.
// Per item: a zero key or unused command goes straight to the result; any
// other item hashes the key and reads the bucket head, then inserts or walks
// the chain. The next item can be taken in the same cycle as the previous
// result becomes valid.
// The chain walk is paced by the registered pool memory read: a link is read,
// then compared. One item is in work at a time; in_stall is low only when idle.
// The output register holds the result while out_stall is high; the next item
// may be taken meanwhile but its result waits for the register to free up.
// After reset a clearing pass writes every bucket head empty, with in_stall
// high throughout.
module chained_hash_map import cmap_pkg::*; #(
	parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
	parameter int KEY_BITS     = KEY_BITS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF,
	localparam int PW = $clog2(POOL_ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            cmd,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [VALUE_BITS-1:0] value_out,
	output logic [PW-1:0]         entry_total
);
	cmap_cmd_t ctl_cmd;
	cmap_sts_t dp_sts;

	// Controller: decides each step of the item from datapath flags.
	cmap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	// Datapath: memories, hashing, pointers, output register.
	cmap_dp #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.POOL_ENTRIES (POOL_ENTRIES),
		.KEY_BITS     (KEY_BITS),
		.VALUE_BITS   (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_in      (cmd),
		.key         (key),
		.value_in    (value_in),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.value_out   (value_out),
		.entry_total (entry_total),
		.cmd         (ctl_cmd),
		.sts         (dp_sts)
	);
endmodule

>>> tb/chained_hash_map_check.sv
// Checker for the chained hash map: predicts every result and compares it.
`timescale 1ns / 1ps
module chained_hash_map_check import cmap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	input  logic [31:0] value_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [31:0] value_out,
	input  logic [8:0]  entry_total,
	output int          fail_count,
	output int          awaited
);
	localparam int BUCKETS = 255;
	localparam int SLOTS   = 256;
	localparam logic [8:0] NULL_SLOT = 9'd256;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] val;
		logic [8:0]  total;
	} map_result_t;

	logic [8:0]  chain_head [BUCKETS];
	logic [31:0] slot_key [SLOTS];
	logic [31:0] slot_val [SLOTS];
	logic [8:0]  slot_next [SLOTS];
	logic [8:0]  free_list;
	logic [8:0]  fresh_slot;
	logic [8:0]  live;
	map_result_t map_results [$];

	initial begin
		for (int i = 0; i < BUCKETS; i++) chain_head[i] = NULL_SLOT;
		free_list  = NULL_SLOT;
		fresh_slot = '0;
		live       = '0;
		fail_count = 0;
	end

	assign awaited = map_results.size();

	function automatic map_result_t apply_map_op(logic [1:0] c, logic [31:0] k,
			logic [31:0] v);
		map_result_t r;
		int b;
		logic [8:0] s, prev, cur;
		int steps;
		r = '{st: ST_OK, val: '0, total: '0};
		b = k % BUCKETS;
		if (c != CMD_NOP && k == 0) begin
			r.st = ST_BADKEY;
		end else if (c == CMD_INSERT) begin
			if (free_list != NULL_SLOT) begin
				s = free_list;
				free_list = slot_next[s];
			end else if (fresh_slot < SLOTS) begin
				s = fresh_slot;
				fresh_slot++;
			end else begin
				s = NULL_SLOT;
			end
			if (s == NULL_SLOT) begin
				r.st = ST_FULL;
			end else begin
				slot_key[s]   = k;
				slot_val[s]   = v;
				slot_next[s]  = chain_head[b];
				chain_head[b] = s;
				live++;
			end
		end else if (c == CMD_DELETE || c == CMD_LOOKUP) begin
			prev  = NULL_SLOT;
			cur   = chain_head[b];
			steps = 0;
			while (cur != NULL_SLOT && steps < SLOTS && slot_key[cur] != k) begin
				prev = cur;
				cur  = slot_next[cur];
				steps++;
			end
			if (cur == NULL_SLOT || steps >= SLOTS) begin
				r.st = ST_MISSING;
			end else if (c == CMD_LOOKUP) begin
				r.val = slot_val[cur];
			end else begin
				if (prev != NULL_SLOT) slot_next[prev] = slot_next[cur];
				else chain_head[b] = slot_next[cur];
				slot_next[cur] = free_list;
				free_list = cur;
				if (live > 0) live--;
			end
		end
		r.total = live;
		return r;
	endfunction

	always @(posedge clk) begin
		map_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				map_results.push_back(apply_map_op(cmd, key, value_in));
			if (out_valid && !out_stall) begin
				if (map_results.size() == 0) begin
					$error("result with nothing expected");
					fail_count++;
				end else begin
					want = map_results.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d got %0d", want.st, status);
						fail_count++;
					end
					if (value_out !== want.val) begin
						$error("value_out: expected %h got %h", want.val, value_out);
						fail_count++;
					end
					if (entry_total !== want.total) begin
						$error("entry_total: expected %0d got %0d", want.total, entry_total);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

>>> tb/chained_hash_map_test.sv
// Stimulus, idling and verdict for the chained hash map.
`timescale 1ns / 1ps
module chained_hash_map_test;
	import cmap_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        in_valid = 1'b0;
	logic        out_stall = 1'b0;
	logic [1:0]  cmd = CMD_NOP;
	logic [31:0] key = '0;
	logic [31:0] value_in = '0;
	logic        in_stall, out_valid;
	logic [1:0]  status;
	logic [31:0] value_out;
	logic [8:0]  entry_total;
	int          fail_count, awaited;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	bit          long_hold_done = 1'b0;
	logic [31:0] key_set [48];

	chained_hash_map dut (.*);

	chained_hash_map_check check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(bit busy);
		int r;
		r = $urandom_range(0, 99);
		if (busy || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a falling edge; returns at the falling edge after the item
	// is taken, or after the idle gap that follows it. in_stall is stable between
	// edges, so the falling-edge value is the one the rising edge will see.
	task automatic send_item(logic [1:0] c, logic [31:0] k, logic [31:0] v, bit busy);
		bit taken;
		int gap;
		in_valid <= 1'b1;
		cmd      <= c;
		key      <= k;
		value_in <= v;
		do begin
			taken = !in_stall;
			@(negedge clk);
		end while (!taken);
		items_sent++;
		gap = pick_gap(busy);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// keys mostly from a small set so chains, hits and shadowing occur
	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return '0;
		if (r < 12) return $urandom();
		return key_set[$urandom_range(0, 47)];
	endfunction

	task automatic random_mix(int n, int ins_w, int del_w);
		int r;
		logic [1:0] c;
		bit busy;
		for (int i = 0; i < n; i++) begin
			busy = ((i / 40) % 3) == 2;
			r = $urandom_range(0, 99);
			if (r < 2) c = CMD_NOP;
			else if (r < ins_w) c = CMD_INSERT;
			else if (r < ins_w + del_w) c = CMD_DELETE;
			else c = CMD_LOOKUP;
			send_item(c, pick_key(), $urandom(), busy);
		end
	endtask

	// receiver: random stalls, quiet stretches, and one long hold-off
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && items_sent >= 120) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				long_hold_done = 1'b1;
			end else if ((items_sent / 60) % 4 == 1) begin
				out_stall <= 1'b0;
			end else begin
				hold = $urandom_range(0, 99);
				if (hold < 3) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(10, 60)) @(negedge clk);
				end else begin
					out_stall <= (hold < 30);
				end
			end
		end
	end

	// watchdog: slowest item walks a full chain while the receiver holds
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 8000) begin
			$display("chained_hash_map regression: fail");
			$finish;
		end
	end

	initial begin
		// reset falls after time zero so the edge is seen
		#1 arst_n = 1'b0;
		for (int i = 0; i < 48; i++) begin
			if (i < 6) key_set[i] = i + 1;
			else if (i < 16) key_set[i] = 32'd255 * (i - 5);   // all bucket zero
			else if (i < 22) key_set[i] = 32'd7 + 32'd255 * $urandom_range(1, 9999);
			else key_set[i] = $urandom() | 32'h1;
		end
		key_set[47] = 32'hFFFF_FFFF;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every command, zero key, misses, shadowing, extremes
		send_item(CMD_LOOKUP, 32'd1, '0, 0);             // empty map
		send_item(CMD_DELETE, 32'd1, '0, 0);
		send_item(CMD_INSERT, 32'd0, 32'hDEAD_BEEF, 0);  // zero key each cmd
		send_item(CMD_DELETE, 32'd0, '0, 0);
		send_item(CMD_LOOKUP, 32'd0, '0, 0);
		send_item(CMD_NOP, 32'd0, '0, 0);
		send_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(CMD_INSERT, 32'd1, 32'd0, 0);
		send_item(CMD_INSERT, 32'd256, 32'h1234_5678, 0); // same bucket as 1
		send_item(CMD_INSERT, 32'd1, 32'hAAAA_5555, 0);   // shadows older 1
		send_item(CMD_LOOKUP, 32'd1, '0, 0);
		send_item(CMD_DELETE, 32'd1, '0, 0);
		send_item(CMD_LOOKUP, 32'd1, '0, 0);              // older entry back
		send_item(CMD_LOOKUP, 32'd256, '0, 0);
		send_item(CMD_LOOKUP, 32'd511, '0, 0);            // miss, same bucket
		send_item(CMD_DELETE, 32'd256, '0, 0);            // head-of-chain unlink
		send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '0, 0);
		send_item(CMD_DELETE, 32'hFFFF_FFFF, '0, 0);
		send_item(CMD_INSERT, 32'h8000_0000, 32'h5555_AAAA, 0); // reuses freed slot
		send_item(CMD_LOOKUP, 32'h8000_0000, '0, 0);

		random_mix(180, 45, 20);

		// fill the pool past full, then delete from it
		random_mix(290, 90, 3);
		in_valid <= 1'b0;
		wait (awaited == 0);
		@(negedge clk);
		random_mix(160, 15, 60);

		in_valid <= 1'b0;
		wait (awaited == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("chained_hash_map regression: pass");
		end else begin
			$display("chained_hash_map regression: fail");
		end
		$finish;
	end
endmodule
